/* src/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, codes and helper functions of the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0]  PAD_CHAR  = 8'h3D;  // '='
  localparam logic [23:0] COUNT_MAX = 24'hFF_FFFF;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_CHAR = 2'd1,
    STATUS_BAD_LEN  = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0]  data;
    status_t     status;
    logic        eom;
    logic [23:0] count;
  } result_t;

  typedef struct packed {
    logic [1:0]  pos;     // index of the next character in its group
    logic [17:0] acc;     // sextets gathered so far
    logic        pad;     // '=' taken at group position 2
    logic        disc;    // error reported, drop until the final character
    logic [23:0] total;   // saturating byte count of the message
  } dec_state_t;

  // Bit 6 set means the character is not in the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] v;
    if (c inside {[8'h41:8'h5A]}) begin
      v = {1'b0, 6'(c - 8'h41)};
    end else if (c inside {[8'h61:8'h7A]}) begin
      v = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c inside {[8'h30:8'h39]}) begin
      v = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      v = 7'h3E;
    end else if (c == 8'h2F) begin
      v = 7'h3F;
    end else begin
      v = 7'h7F;
    end
    return v;
  endfunction

  function automatic logic [23:0] sat_add(input logic [23:0] b, input logic [1:0] k);
    logic [24:0] s;
    s = {1'b0, b} + 25'(k);
    if (s > {1'b0, COUNT_MAX}) begin
      return COUNT_MAX;
    end
    return s[23:0];
  endfunction

endpackage

/* src/b64d_decode.sv */
// ----------------------------------------------------------------------------
// b64d_decode
// Per-character decode step: next state and up to three results.
// ----------------------------------------------------------------------------
module b64d_decode import b64d_pkg::*; (
  input  dec_state_t             st,
  input  logic [7:0]             char_code,
  input  logic                   final_char,
  output dec_state_t             st_next,
  output logic [RES_CNT_W-1:0]   num_res,
  output result_t                res [MAX_RESULTS]
);

  logic [6:0]  sx;
  logic [23:0] word;
  logic [23:0] cnt1;
  logic [23:0] cnt2;
  logic [23:0] cnt3;
  status_t     err;

  assign sx   = sextet_of(char_code);
  assign word = {st.acc, sx[5:0]};
  assign cnt1 = sat_add(st.total, 2'd1);
  assign cnt2 = sat_add(st.total, 2'd2);
  assign cnt3 = sat_add(st.total, 2'd3);

  always_comb begin
    st_next = st;
    num_res = '0;
    err     = STATUS_OK;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i] = '0;
    end

    if (st.disc) begin
      if (final_char) begin
        st_next = '0;
      end
    end else if (st.pos == 2'd3 && st.pad) begin
      if (char_code == PAD_CHAR && final_char) begin
        res[0]  = '{data: st.acc[11:4], status: STATUS_OK, eom: 1'b1, count: cnt1};
        num_res = RES_CNT_W'(1);
        st_next = '0;
      end else begin
        err = STATUS_BAD_CHAR;
      end
    end else if (char_code == PAD_CHAR) begin
      if (st.pos == 2'd2) begin
        if (final_char) begin
          err = STATUS_BAD_LEN;
        end else begin
          st_next.pad = 1'b1;
          st_next.pos = 2'd3;
        end
      end else if (st.pos == 2'd3 && final_char) begin
        res[0]  = '{data: st.acc[17:10], status: STATUS_OK, eom: 1'b0, count: cnt1};
        res[1]  = '{data: st.acc[9:2], status: STATUS_OK, eom: 1'b1, count: cnt2};
        num_res = RES_CNT_W'(2);
        st_next = '0;
      end else begin
        err = STATUS_BAD_CHAR;
      end
    end else if (sx[6]) begin
      err = STATUS_BAD_CHAR;
    end else if (st.pos == 2'd3) begin
      res[0]  = '{data: word[23:16], status: STATUS_OK, eom: 1'b0, count: cnt1};
      res[1]  = '{data: word[15:8], status: STATUS_OK, eom: 1'b0, count: cnt2};
      res[2]  = '{data: word[7:0], status: STATUS_OK, eom: final_char, count: cnt3};
      num_res = RES_CNT_W'(3);
      if (final_char) begin
        st_next = '0;
      end else begin
        st_next.pos   = 2'd0;
        st_next.acc   = '0;
        st_next.pad   = 1'b0;
        st_next.total = cnt3;
      end
    end else begin
      st_next.acc = {st.acc[11:0], sx[5:0]};
      st_next.pos = st.pos + 2'd1;
      if (final_char) begin
        err = STATUS_BAD_LEN;
      end
    end

    if (err != STATUS_OK) begin
      res[0]  = '{data: 8'h00, status: err, eom: 1'b1, count: st.total};
      num_res = RES_CNT_W'(1);
      if (final_char) begin
        st_next = '0;
      end else begin
        st_next.disc = 1'b1;
      end
    end
  end

endmodule

/* src/b64d_outbuf.sv */
// ----------------------------------------------------------------------------
// b64d_outbuf
// Holds the results of one character and hands them out one per transfer.
// ----------------------------------------------------------------------------
module b64d_outbuf import b64d_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic [RES_CNT_W-1:0] num_res,
  input  result_t              res [MAX_RESULTS],
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic                 free,
  output result_t              head
);

  logic [RES_CNT_W-1:0] count;
  result_t              slot [MAX_RESULTS];
  logic                 take;

  assign out_valid = (count != '0);
  assign take      = out_valid && !out_stall;
  // free when empty, or when the last entry leaves this cycle
  assign free      = (count == '0) || (count == RES_CNT_W'(1) && take);
  assign head      = slot[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load && num_res != '0) begin
      count <= num_res;
    end else if (take) begin
      count <= count - RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load && num_res != '0) begin
      slot <= res;
    end else if (take) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        slot[i] <= slot[i+1];
      end
    end
  end

endmodule

/* src/base64_stream_decoder.sv */
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Base64 (standard alphabet) decoder, one character in, decoded bytes out.
// ----------------------------------------------------------------------------
// One character is taken per cycle into an input register and decoded in the
// next cycle; results leave from a three-entry result buffer, one per
// transfer, once the decode step has loaded them there. Characters that
// yield no result pass at one per cycle regardless of the output side. A
// character that completes a group yields up to three bytes and is held in
// the input register until the result buffer has drained the previous
// group, so a steady stream of four characters per three bytes runs at one
// character per cycle when the output takes a transfer every cycle. Errors
// give one result with end_of_message set; the rest of the message is then
// dropped up to final_char.
module base64_stream_decoder import b64d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        final_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  data_byte,
  output logic [1:0]  status,
  output logic        end_of_message,
  output logic [23:0] decoded_count
);

  logic                 r_valid;
  logic [7:0]           r_char;
  logic                 r_final;
  dec_state_t           st;
  dec_state_t           st_next;
  logic [RES_CNT_W-1:0] num_res;
  result_t              res [MAX_RESULTS];
  result_t              head;
  logic                 free;
  logic                 advance;
  logic                 accept;

  b64d_decode u_decode (
    .st         (st),
    .char_code  (r_char),
    .final_char (r_final),
    .st_next    (st_next),
    .num_res    (num_res),
    .res        (res)
  );

  assign advance  = r_valid && (num_res == '0 || free);
  assign in_stall = r_valid && !advance;
  assign accept   = in_valid && !in_stall;

  b64d_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .num_res   (num_res),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .free      (free),
    .head      (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
      st      <= '0;
    end else begin
      if (accept) begin
        r_valid <= 1'b1;
      end else if (advance) begin
        r_valid <= 1'b0;
      end
      if (advance) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_char  <= char_code;
      r_final <= final_char;
    end
  end

  assign data_byte      = head.data;
  assign status         = head.status;
  assign end_of_message = head.eom;
  assign decoded_count  = head.count;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for base64_stream_decoder. A short list of hand-picked
// characters (alphabet extremes, padding, bad characters and bad lengths)
// is followed by random messages, mostly well formed with some corrupted.
// Each accepted character runs through a local decoder model; every output
// transfer is compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_top;
  import b64d_pkg::*;

  localparam int RANDOM_ITEMS = 470;

  typedef struct packed {
    logic [7:0] c;
    logic       fin;
    logic       typed;   // expected result given in the row itself
    status_t    st;
  } stim_row_t;

  // Typed rows are all error results: data 0, end_of_message 1, count 0.
  localparam stim_row_t DIRECTED_ROWS [26] = '{
    {"A",   1'b0, 1'b0, STATUS_OK},
    {"=",   1'b0, 1'b1, STATUS_BAD_CHAR},  // pad at position 1, drop follows
    {"Z",   1'b1, 1'b0, STATUS_OK},        // dropped, ends the message
    {"A",   1'b0, 1'b0, STATUS_OK},
    {8'hFF, 1'b1, 1'b1, STATUS_BAD_CHAR},  // bad char and short group at once
    {"z",   1'b1, 1'b1, STATUS_BAD_LEN},
    {"/",   1'b0, 1'b0, STATUS_OK},
    {"/",   1'b0, 1'b0, STATUS_OK},
    {"/",   1'b0, 1'b0, STATUS_OK},
    {"/",   1'b0, 1'b0, STATUS_OK},
    {"A",   1'b0, 1'b0, STATUS_OK},
    {"A",   1'b0, 1'b0, STATUS_OK},
    {"=",   1'b0, 1'b0, STATUS_OK},
    {"=",   1'b1, 1'b0, STATUS_OK},
    {"+",   1'b0, 1'b0, STATUS_OK},
    {"9",   1'b0, 1'b0, STATUS_OK},
    {"z",   1'b0, 1'b0, STATUS_OK},
    {"=",   1'b1, 1'b0, STATUS_OK},
    {"A",   1'b0, 1'b0, STATUS_OK},
    {"B",   1'b0, 1'b0, STATUS_OK},
    {"=",   1'b0, 1'b0, STATUS_OK},
    {"C",   1'b1, 1'b1, STATUS_BAD_CHAR},  // data after a pad, final item
    {"A",   1'b0, 1'b0, STATUS_OK},
    {"B",   1'b0, 1'b0, STATUS_OK},
    {"=",   1'b1, 1'b1, STATUS_BAD_LEN},   // message ends on the first pad
    {"=",   1'b1, 1'b1, STATUS_BAD_CHAR}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  char_code = 8'h00;
  logic        final_char = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  data_byte;
  logic [1:0]  status;
  logic        end_of_message;
  logic [23:0] decoded_count;

  // payload side info, stable while in_valid is high
  logic        row_typed = 1'b0;
  status_t     row_status = STATUS_OK;

  bit          in_quiet = 1'b0;
  bit          out_quiet = 1'b0;
  int          items_sent = 0;
  int          error_count = 0;

  result_t     pending_bytes [$];
  result_t     new_results [$];

  // decoder model state
  logic [1:0]  grp_pos;
  logic [17:0] acc;
  logic        pad_third;
  logic        dropping;
  logic [23:0] msg_bytes;

  base64_stream_decoder dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .char_code      (char_code),
    .final_char     (final_char),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .data_byte      (data_byte),
    .status         (status),
    .end_of_message (end_of_message),
    .decoded_count  (decoded_count)
  );

  always #5 clk = ~clk;

  // -------------------------------------------------------------------------
  // Decoder model
  // -------------------------------------------------------------------------
  function automatic int char_value(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return c - "A";
    if (c >= "a" && c <= "z") return c - "a" + 26;
    if (c >= "0" && c <= "9") return c - "0" + 52;
    if (c == "+") return 62;
    if (c == "/") return 63;
    return -1;
  endfunction

  function automatic logic [7:0] alpha_char(input int idx);
    if (idx < 26) return 8'("A" + idx);
    if (idx < 52) return 8'("a" + idx - 26);
    if (idx < 62) return 8'("0" + idx - 52);
    if (idx == 62) return "+";
    return "/";
  endfunction

  task automatic clear_msg();
    grp_pos   = 2'd0;
    acc       = 18'd0;
    pad_third = 1'b0;
    dropping  = 1'b0;
    msg_bytes = 24'd0;
  endtask

  task automatic emit_byte(input logic [7:0] d, input logic eom);
    result_t r;
    if (msg_bytes != COUNT_MAX) msg_bytes = msg_bytes + 24'd1;
    r.data   = d;
    r.status = STATUS_OK;
    r.eom    = eom;
    r.count  = msg_bytes;
    new_results.push_back(r);
  endtask

  task automatic flag_error(input status_t st, input logic fin);
    result_t r;
    r.data   = 8'h00;
    r.status = st;
    r.eom    = 1'b1;
    r.count  = msg_bytes;
    new_results.push_back(r);
    if (fin) clear_msg();
    else dropping = 1'b1;
  endtask

  task automatic decode_char(input logic [7:0] c, input logic fin);
    int          v;
    logic [23:0] word;
    if (dropping) begin
      if (fin) clear_msg();
      return;
    end
    // "xx=" so far: only a final '=' is legal
    if (grp_pos == 2'd3 && pad_third) begin
      if (c == PAD_CHAR && fin) begin
        emit_byte(acc[11:4], 1'b1);
        clear_msg();
      end else begin
        flag_error(STATUS_BAD_CHAR, fin);
      end
      return;
    end
    if (c == PAD_CHAR) begin
      if (grp_pos == 2'd2 && fin) begin
        flag_error(STATUS_BAD_LEN, fin);
      end else if (grp_pos == 2'd2) begin
        pad_third = 1'b1;
        grp_pos   = 2'd3;
      end else if (grp_pos == 2'd3 && fin) begin
        emit_byte(acc[17:10], 1'b0);
        emit_byte(acc[9:2], 1'b1);
        clear_msg();
      end else begin
        flag_error(STATUS_BAD_CHAR, fin);
      end
      return;
    end
    v = char_value(c);
    if (v < 0) begin
      flag_error(STATUS_BAD_CHAR, fin);
      return;
    end
    if (grp_pos == 2'd3) begin
      word = {acc, 6'(v)};
      emit_byte(word[23:16], 1'b0);
      emit_byte(word[15:8], 1'b0);
      emit_byte(word[7:0], fin);
      if (fin) begin
        clear_msg();
      end else begin
        grp_pos   = 2'd0;
        acc       = 18'd0;
        pad_third = 1'b0;
      end
      return;
    end
    acc     = {acc[11:0], 6'(v)};
    grp_pos = grp_pos + 2'd1;
    if (fin) flag_error(STATUS_BAD_LEN, fin);
  endtask

  // -------------------------------------------------------------------------
  // Checking
  // -------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    $display("%0t: mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t typed_res;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_bytes.size() == 0) begin
          report_mismatch("result with nothing pending", {16'd0, data_byte}, 24'd0);
        end else begin
          want = pending_bytes.pop_front();
          if (data_byte !== want.data)
            report_mismatch("data_byte", {16'd0, data_byte}, {16'd0, want.data});
          if (status !== want.status)
            report_mismatch("status", {22'd0, status}, {22'd0, want.status});
          if (end_of_message !== want.eom)
            report_mismatch("end_of_message", {23'd0, end_of_message}, {23'd0, want.eom});
          if (decoded_count !== want.count)
            report_mismatch("decoded_count", decoded_count, want.count);
        end
      end
      if (in_valid && !in_stall) begin
        new_results.delete();
        decode_char(char_code, final_char);
        if (row_typed) begin
          typed_res.data   = 8'h00;
          typed_res.status = row_status;
          typed_res.eom    = 1'b1;
          typed_res.count  = 24'd0;
          pending_bytes.push_back(typed_res);
        end else begin
          foreach (new_results[i]) pending_bytes.push_back(new_results[i]);
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_char(input logic [7:0] c, input logic fin, input logic typed,
                           input status_t st);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    char_code  = c;
    final_char = fin;
    row_typed  = typed;
    row_status = st;
    in_valid   = 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_message();
    logic [7:0] msg [$];
    int         n_groups;
    int         pad;
    int         mode;
    int         pos;
    n_groups = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
    pad      = $urandom_range(0, 2);
    mode     = $urandom_range(0, 9);
    for (int i = 0; i < 4 * n_groups; i++) msg.push_back(alpha_char($urandom_range(0, 63)));
    if (pad >= 1) msg[msg.size() - 1] = PAD_CHAR;
    if (pad == 2) msg[msg.size() - 2] = PAD_CHAR;
    case (mode)
      7: begin
        // corrupt one character, often with a stray pad
        pos = $urandom_range(0, msg.size() - 1);
        msg[pos] = ($urandom_range(0, 2) == 0) ? PAD_CHAR : 8'($urandom_range(0, 255));
      end
      8: begin
        // cut the message short inside its last group
        repeat ($urandom_range(1, 3)) msg.pop_back();
      end
      9: begin
        msg.delete();
        repeat ($urandom_range(1, 6))
          msg.push_back(($urandom_range(0, 3) == 0) ? PAD_CHAR : 8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    in_quiet = ($urandom_range(0, 4) == 0);
    foreach (msg[i]) send_char(msg[i], (i == msg.size() - 1), 1'b0, STATUS_OK);
  endtask

  // output side: random stall ahead of each transfer, with quiet stretches
  initial begin
    int gap;
    wait (!rst);
    forever begin
      @(negedge clk);
      gap = out_quiet ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_stall = 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      if ($urandom_range(0, 24) == 0) out_quiet = !out_quiet;
    end
  end

  initial begin
    clear_msg();
    repeat (10) @(negedge clk);
    rst = 1'b0;
    foreach (DIRECTED_ROWS[i])
      send_char(DIRECTED_ROWS[i].c, DIRECTED_ROWS[i].fin, DIRECTED_ROWS[i].typed,
                DIRECTED_ROWS[i].st);
    while (items_sent < $size(DIRECTED_ROWS) + RANDOM_ITEMS) send_message();
    in_valid = 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* base64_stream_decoder.f */
src/b64d_pkg.sv
src/b64d_decode.sv
src/b64d_outbuf.sv
src/base64_stream_decoder.sv
verif/tb_top.sv
